>>> design/spxp_pkg.sv
// Shared types and constants for the sequence-pair x packer.
package spxp_pkg;

   localparam int MAX_BLOCKS_DEF = 64;
   localparam int WIDTH_BITS_DEF = 16;

   localparam int ID_W     = 6;
   localparam int POS_IN_W = 6;
   localparam int WID_IN_W = 16;
   localparam int X_W      = 22;

   localparam logic [X_W-1:0] X_MAX = X_W'(4194240);

   typedef struct packed {
      logic valid;
      logic first;
      logic kill;
   } spxp_ctl_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [X_W-1:0]  x;
      logic [X_W-1:0]  right_edge;
   } spxp_data_type;

endpackage

>>> design/spxp_ifs.sv
// Request and response channel interfaces of the sequence-pair x packer.
interface spxp_req_if import spxp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     block_id;
   logic [POS_IN_W-1:0] neg_position;
   logic [WID_IN_W-1:0] block_width;
   logic                first_block;

   modport source (output valid, block_id, neg_position, block_width, first_block,
                   input ready);
   modport sink   (input valid, block_id, neg_position, block_width, first_block,
                   output ready);
endinterface

interface spxp_rsp_if import spxp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] result_block_id;
   logic [X_W-1:0]  x_position;

   modport source (output valid, result_block_id, x_position, input ready);
   modport sink   (input valid, result_block_id, x_position, output ready);
endinterface

>>> design/spxp_cell.sv
// One staircase cell: holds the entry for one negative position and updates a passing request.
module spxp_cell import spxp_pkg::*; #(
   parameter int INDEX = 0,
   parameter int POS_W = 6,
   parameter int W_W   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  spxp_ctl_type       in_ctl,
   input  spxp_data_type      in_data,
   input  logic [POS_W-1:0]   in_pos,
   input  logic [W_W-1:0]     in_width,
   output spxp_ctl_type       out_ctl,
   output spxp_data_type      out_data,
   output logic [POS_W-1:0]   out_pos,
   output logic [W_W-1:0]     out_width
);

   localparam int SUM_W = ((W_W > X_W) ? W_W : X_W) + 1;
   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic               valid_ff, valid_in;
   logic [X_W-1:0]     stair_edge_ff, stair_edge_in;
   spxp_ctl_type       ctl_ff, ctl_in;
   spxp_data_type      data_ff, data_in;
   logic [POS_W-1:0]   pos_ff;
   logic [W_W-1:0]     width_ff;

   logic               here_v;
   logic               at_pos;
   logic               below_pos;
   logic [X_W-1:0]     x_sel;
   logic [SUM_W-1:0]   sum;
   logic [X_W-1:0]     sat_edge;

   assign here_v    = valid_ff & ~in_ctl.first;
   assign at_pos    = (in_pos == MY_POS);
   assign below_pos = (MY_POS < in_pos);
   assign x_sel     = here_v ? stair_edge_ff : in_data.x;
   assign sum       = SUM_W'(x_sel) + SUM_W'(in_width);
   assign sat_edge  = (sum > SUM_W'(X_MAX)) ? X_MAX : sum[X_W-1:0];

   always_comb begin
      ctl_in        = in_ctl;
      data_in       = in_data;
      valid_in      = valid_ff;
      stair_edge_in = stair_edge_ff;
      if (in_ctl.valid) begin
         valid_in = here_v;
         priority if (below_pos) begin
            if (here_v) begin
               data_in.x = stair_edge_ff;
            end
         end else if (at_pos) begin
            data_in.x          = x_sel;
            data_in.right_edge = sat_edge;
            ctl_in.kill        = 1'b1;
            valid_in           = 1'b1;
            stair_edge_in      = sat_edge;
         end else begin
            if (in_ctl.kill && here_v) begin
               if (stair_edge_ff <= in_data.right_edge) begin
                  valid_in = 1'b0;
               end else begin
                  ctl_in.kill = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctl_ff   <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
         ctl_ff   <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stair_edge_ff <= stair_edge_in;
         data_ff       <= data_in;
         pos_ff        <= in_pos;
         width_ff      <= in_width;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_data  = data_ff;
   assign out_pos   = pos_ff;
   assign out_width = width_ff;

endmodule

>>> design/sequence_pair_x_packer_core.sv
// Sequence-pair x packer: top level with request intake and the row of staircase cells.
// Each request carries a block id, its negative-sequence position, its width and a
// first-block flag that empties the staircase. Each request yields exactly one response
// with the block id and the block's left edge x, saturated at 4194240.
// A request travels the row of MAX_BLOCKS cells, one cell per cycle while the row advances;
// cell k owns the staircase entry of position k. Below its own position the request picks up
// the edge of the highest present entry, at its position it stores x + width, above it drops
// entries no higher than the new edge until it meets a taller one.
// Requests overlap in the row, so one request is taken every cycle while the row advances.
// Reset empties the staircase and the row; no clearing pass is needed.
// While the response waits and rsp ready is low, the whole row holds and req ready is low.
module sequence_pair_x_packer_core import spxp_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   spxp_req_if.sink    req_if,
   spxp_rsp_if.source  rsp_if
);

   localparam int POS_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
   localparam int EXT_W = (POS_W > POS_IN_W) ? POS_W : POS_IN_W;
   localparam int W_W   = (WIDTH_BITS < WID_IN_W) ? WIDTH_BITS : WID_IN_W;

   spxp_ctl_type      ctl_w   [MAX_BLOCKS+1];
   spxp_data_type     data_w  [MAX_BLOCKS+1];
   logic [POS_W-1:0]  pos_w   [MAX_BLOCKS+1];
   logic [W_W-1:0]    width_w [MAX_BLOCKS+1];

   logic              advance;
   logic [EXT_W-1:0]  pos_ext;
   logic [EXT_W-1:0]  pos_clamp;

   assign advance      = ~ctl_w[MAX_BLOCKS].valid | rsp_if.ready;
   assign req_if.ready = advance;

   assign pos_ext   = EXT_W'(req_if.neg_position);
   assign pos_clamp = (pos_ext >= EXT_W'(MAX_BLOCKS - 1)) ? EXT_W'(MAX_BLOCKS - 1) : pos_ext;

   always_comb begin
      ctl_w[0].valid        = req_if.valid;
      ctl_w[0].first        = req_if.first_block;
      ctl_w[0].kill         = 1'b0;
      data_w[0].id          = req_if.block_id;
      data_w[0].x           = '0;
      data_w[0].right_edge  = '0;
      pos_w[0]              = pos_clamp[POS_W-1:0];
      width_w[0]            = req_if.block_width[W_W-1:0];
   end

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      spxp_cell #(
         .INDEX (i),
         .POS_W (POS_W),
         .W_W   (W_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_ctl    (ctl_w[i]),
         .in_data   (data_w[i]),
         .in_pos    (pos_w[i]),
         .in_width  (width_w[i]),
         .out_ctl   (ctl_w[i+1]),
         .out_data  (data_w[i+1]),
         .out_pos   (pos_w[i+1]),
         .out_width (width_w[i+1])
      );
   end

   assign rsp_if.valid           = ctl_w[MAX_BLOCKS].valid;
   assign rsp_if.result_block_id = data_w[MAX_BLOCKS].id;
   assign rsp_if.x_position      = data_w[MAX_BLOCKS].x;

endmodule
